FILE: hdl/cgm_pkg.sv
package cgm_pkg;

  localparam int unsigned NormSteps  = 17;
  localparam int unsigned BlendSteps = 8;

  localparam logic CMD_ADD    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic [1:0] KIND_COLOR   = 2'd0;
  localparam logic [1:0] KIND_STORED  = 2'd1;
  localparam logic [1:0] KIND_DROPPED = 2'd2;

  localparam logic [1:0] REG_MIN   = 2'd0;
  localparam logic [1:0] REG_CLAMP = 2'd1;
  localparam logic [1:0] REG_CAT   = 2'd2;

  localparam logic [16:0] NORM_SAT = 17'h1FFFF;

  typedef enum logic [2:0] {
    OUT_NONE,
    OUT_ADD,
    OUT_LO,
    OUT_BLEND,
    OUT_CAT,
    OUT_CAT_BLACK
  } out_sel_e;

  typedef struct packed {
    logic     load;
    logic     norm_init;
    logic     norm_step;
    logic     walk_step;
    logic     blend_init;
    logic     blend_step;
    logic     cat_init;
    logic     cat_step;
    out_sel_e out_sel;
  } cgm_cmd_t;

  typedef struct packed {
    logic is_add;
    logic cat_mode;
    logic norm_skip;
    logic walk_end;
    logic walk_hit;
    logic count_zero;
  } cgm_sts_t;

endpackage

FILE: hdl/cgm_ctrl.sv
module cgm_ctrl
  import cgm_pkg::*;
#(
  parameter int unsigned CatSteps = 21
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  cgm_sts_t sts_i,
  output cgm_cmd_t cmd_o,
  output logic     busy_o
);

  localparam int unsigned CNTW = $clog2(CatSteps);

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b00000001,
    ST_DISP  = 8'b00000010,
    ST_NORM  = 8'b00000100,
    ST_WALK  = 8'b00001000,
    ST_BLEND = 8'b00010000,
    ST_BOUT  = 8'b00100000,
    ST_CAT   = 8'b01000000,
    ST_COUT  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.out_sel = OUT_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_DISP;
        end
      end
      ST_DISP: begin
        if (sts_i.is_add) begin
          cmd_o.out_sel = OUT_ADD;
          state_d       = ST_IDLE;
        end else if (sts_i.cat_mode) begin
          if (sts_i.count_zero) begin
            cmd_o.out_sel = OUT_CAT_BLACK;
            state_d       = ST_IDLE;
          end else begin
            cmd_o.cat_init = 1'b1;
            cnt_d          = CNTW'(CatSteps - 1);
            state_d        = ST_CAT;
          end
        end else begin
          cmd_o.norm_init = 1'b1;
          cnt_d           = CNTW'(NormSteps - 1);
          state_d         = sts_i.norm_skip ? ST_WALK : ST_NORM;
        end
      end
      ST_NORM: begin
        cmd_o.norm_step = 1'b1;
        cnt_d           = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (sts_i.walk_end) begin
          cmd_o.out_sel = OUT_LO;
          state_d       = ST_IDLE;
        end else if (sts_i.walk_hit) begin
          cmd_o.blend_init = 1'b1;
          cnt_d            = CNTW'(BlendSteps - 1);
          state_d          = ST_BLEND;
        end else begin
          cmd_o.walk_step = 1'b1;
        end
      end
      ST_BLEND: begin
        cmd_o.blend_step = 1'b1;
        cnt_d            = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_BOUT;
      end
      ST_BOUT: begin
        cmd_o.out_sel = OUT_BLEND;
        state_d       = ST_IDLE;
      end
      ST_CAT: begin
        cmd_o.cat_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = ST_COUT;
      end
      ST_COUT: begin
        cmd_o.out_sel = OUT_CAT;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

FILE: hdl/cgm_dp.sv
module cgm_dp
  import cgm_pkg::*;
#(
  parameter int unsigned MaxStops = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cgm_cmd_t           cmd_i,
  output cgm_sts_t           sts_o,
  input  logic signed [31:0] min_value_i,
  input  logic signed [31:0] clamp_value_i,
  input  logic               categorical_mode_i,
  input  logic               item_cmd_i,
  input  logic signed [31:0] sample_value_i,
  input  logic [7:0]         opacity_i,
  input  logic [16:0]        stop_position_i,
  input  logic [7:0]         stop_red_i,
  input  logic [7:0]         stop_green_i,
  input  logic [7:0]         stop_blue_i,
  output logic               done_o,
  output logic [1:0]         kind_o,
  output logic [7:0]         out_red_o,
  output logic [7:0]         out_green_o,
  output logic [7:0]         out_blue_o,
  output logic [7:0]         out_alpha_o
);

  localparam int unsigned CW   = $clog2(MaxStops + 1);
  localparam int unsigned IDXW = (MaxStops > 1) ? $clog2(MaxStops) : 1;
  localparam int unsigned QPW  = CW + 17;

  // stop table, kept sorted
  logic [16:0] pos_q [MaxStops];
  logic [23:0] col_q [MaxStops];
  logic [CW-1:0] count_q;

  // captured item
  logic        cmd_q;
  logic signed [31:0] sample_q;
  logic [7:0]  opacity_q;
  logic [16:0] npos_q;
  logic [23:0] nrgb_q;

  // normalize divider
  logic [34:0] nrem_q;
  logic [32:0] ndiv_q;
  logic [16:0] norm_q;

  // walker
  logic [CW-1:0] w_q;
  logic [16:0]   lo_pos_q;
  logic [23:0]   lo_rgb_q;

  // blend dividers
  logic [25:0] brem_q [3];
  logic [23:0] bdiv_q;
  logic [7:0]  bq_q [3];

  // categorical remainder
  logic [QPW-1:0] csh_q;
  logic [CW-1:0]  crem_q;

  logic [IDXW-1:0] rd_idx;
  logic [16:0]     rd_pos;
  logic [23:0]     rd_col;
  logic            full;

  assign full   = (count_q >= CW'(MaxStops));
  assign rd_idx = categorical_mode_i ? crem_q[IDXW-1:0] : w_q[IDXW-1:0];
  assign rd_pos = pos_q[rd_idx];
  assign rd_col = col_q[rd_idx];

  // normalize setup
  logic signed [32:0] num, den;
  logic [32:0] an, ad;
  logic        den_zero, neg_or_zero, sat;

  always_comb begin
    num = 33'(sample_q) - 33'(min_value_i);
    den = 33'(clamp_value_i) - 33'(min_value_i);
    an  = num[32] ? 33'(-num) : 33'(num);
    ad  = den[32] ? 33'(-den) : 33'(den);
    den_zero    = (den == '0);
    neg_or_zero = (num == '0) || (num[32] != den[32]);
    sat         = ({1'b0, an} >= {ad, 1'b0});
  end

  assign sts_o.is_add     = (cmd_q == CMD_ADD);
  assign sts_o.cat_mode   = categorical_mode_i;
  assign sts_o.norm_skip  = den_zero || neg_or_zero || sat;
  assign sts_o.walk_end   = (w_q == count_q);
  assign sts_o.walk_hit   = (rd_pos > norm_q);
  assign sts_o.count_zero = (count_q == '0);

  // insertion: entry stays where its position is not above the new one
  logic [MaxStops-1:0] keep;
  always_comb begin
    for (int i = 0; i < MaxStops; i++) begin
      keep[i] = (CW'(i) < count_q) && (pos_q[i] <= npos_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_sel == OUT_ADD && !full) begin
      for (int i = 0; i < MaxStops; i++) begin
        if (!keep[i]) begin
          if (i == 0 || keep[(i == 0) ? 0 : i - 1]) begin
            pos_q[i] <= npos_q;
            col_q[i] <= nrgb_q;
          end else begin
            pos_q[i] <= pos_q[(i == 0) ? 0 : i - 1];
            col_q[i] <= col_q[(i == 0) ? 0 : i - 1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_o  <= 1'b0;
    end else begin
      if (cmd_i.out_sel == OUT_ADD && !full) count_q <= count_q + 1'b1;
      done_o <= (cmd_i.out_sel != OUT_NONE);
    end
  end

  // blend numerators
  logic [16:0] bd, bf;
  logic [25:0] bnum [3];
  always_comb begin
    bd = rd_pos - lo_pos_q;
    bf = norm_q - lo_pos_q;
    for (int c = 0; c < 3; c++) begin
      bnum[c] = 26'(lo_rgb_q[8*c +: 8]) * 26'(bd - bf) + 26'(rd_col[8*c +: 8]) * 26'(bf);
    end
  end

  logic signed [32:0] dcat;
  logic [QPW-1:0]     qcat;
  logic [CW:0]        ctry;
  logic [34:0]        nsub;
  assign dcat = 33'(sample_q) - 33'(min_value_i);
  assign qcat = dcat[32] ? (QPW'($signed(dcat[32:16])) + (QPW'(count_q) << 16))
                         : QPW'(dcat[32:16]);
  assign ctry = {crem_q, csh_q[QPW-1]};
  assign nsub = nrem_q - 35'(ndiv_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= item_cmd_i;
      sample_q  <= sample_value_i;
      opacity_q <= opacity_i;
      npos_q    <= stop_position_i;
      nrgb_q    <= {stop_red_i, stop_green_i, stop_blue_i};
      w_q       <= '0;
      lo_pos_q  <= '0;
      lo_rgb_q  <= '0;
    end
    if (cmd_i.norm_init) begin
      nrem_q <= 35'(an);
      ndiv_q <= ad;
      if (den_zero || (!neg_or_zero && sat)) norm_q <= NORM_SAT;
      else norm_q <= '0;
    end
    if (cmd_i.norm_step) begin
      if (!nsub[34]) begin
        nrem_q <= {nsub[33:0], 1'b0};
        norm_q <= {norm_q[15:0], 1'b1};
      end else begin
        nrem_q <= {nrem_q[33:0], 1'b0};
        norm_q <= {norm_q[15:0], 1'b0};
      end
    end
    if (cmd_i.walk_step) begin
      lo_pos_q <= rd_pos;
      lo_rgb_q <= rd_col;
      w_q      <= w_q + 1'b1;
    end
    if (cmd_i.blend_init) begin
      bdiv_q <= {bd, 7'b0};
      for (int c = 0; c < 3; c++) begin
        brem_q[c] <= bnum[c];
        bq_q[c]   <= '0;
      end
    end
    if (cmd_i.blend_step) begin
      bdiv_q <= bdiv_q >> 1;
      for (int c = 0; c < 3; c++) begin
        if (brem_q[c] >= 26'(bdiv_q)) begin
          brem_q[c] <= brem_q[c] - 26'(bdiv_q);
          bq_q[c]   <= {bq_q[c][6:0], 1'b1};
        end else begin
          bq_q[c]   <= {bq_q[c][6:0], 1'b0};
        end
      end
    end
    if (cmd_i.cat_init) begin
      csh_q  <= qcat;
      crem_q <= '0;
    end
    if (cmd_i.cat_step) begin
      csh_q <= csh_q << 1;
      if (ctry >= (CW+1)'(count_q)) crem_q <= CW'(ctry - (CW+1)'(count_q));
      else crem_q <= ctry[CW-1:0];
    end
    case (cmd_i.out_sel)
      OUT_ADD: begin
        kind_o <= full ? KIND_DROPPED : KIND_STORED;
        {out_red_o, out_green_o, out_blue_o, out_alpha_o} <= '0;
      end
      OUT_LO: begin
        kind_o <= KIND_COLOR;
        {out_red_o, out_green_o, out_blue_o} <= lo_rgb_q;
        out_alpha_o <= opacity_q;
      end
      OUT_BLEND: begin
        kind_o <= KIND_COLOR;
        {out_red_o, out_green_o, out_blue_o} <= {bq_q[2], bq_q[1], bq_q[0]};
        out_alpha_o <= opacity_q;
      end
      OUT_CAT: begin
        kind_o <= KIND_COLOR;
        {out_red_o, out_green_o, out_blue_o} <= rd_col;
        out_alpha_o <= 8'hFF;
      end
      OUT_CAT_BLACK: begin
        kind_o <= KIND_COLOR;
        {out_red_o, out_green_o, out_blue_o} <= '0;
        out_alpha_o <= 8'hFF;
      end
      default: ;
    endcase
  end

endmodule

FILE: hdl/color_gradient_map_unit.sv
// Add beat: result strobed out of the dispatch state. Lookup, gradient: normalize
// divider (one quotient bit a cycle, skipped when the result saturates or is zero, or
// when min equals clamp), then stop walk, blend divider and output; past the last stop
// the walk ends without the blend. Lookup, categorical: bit-serial remainder.
// One item at a time; busy covers it.
// rst_ni async low: table empty, registers back to min 0, clamp 1.0, gradient mode.
// Results are strobed for one cycle; the receiver cannot stall.
module color_gradient_map_unit
  import cgm_pkg::*;
#(
  parameter int unsigned MAX_STOPS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command beat
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [31:0] sample_value_i,
  input  logic [7:0]  opacity_i,
  input  logic [16:0] stop_position_i,
  input  logic [7:0]  stop_red_i,
  input  logic [7:0]  stop_green_i,
  input  logic [7:0]  stop_blue_i,
  // result beat
  output logic        done_o,
  output logic [1:0]  kind_o,
  output logic [7:0]  out_red_o,
  output logic [7:0]  out_green_o,
  output logic [7:0]  out_blue_o,
  output logic [7:0]  out_alpha_o,
  // APB config
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned CatSteps = $clog2(MAX_STOPS + 1) + 17;

  logic signed [31:0] min_q, clamp_q;
  logic               cat_q;
  logic               wr_en;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= '0;
      clamp_q <= 32'sd65536;
      cat_q   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_MIN:   min_q   <= pwdata;
        REG_CLAMP: clamp_q <= pwdata;
        REG_CAT:   cat_q   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN:   prdata = min_q;
      REG_CLAMP: prdata = clamp_q;
      REG_CAT:   prdata = {31'b0, cat_q};
      default:   prdata = '0;
    endcase
  end

  cgm_cmd_t cmd;
  cgm_sts_t sts;

  cgm_ctrl #(
    .CatSteps(CatSteps)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy)
  );

  cgm_dp #(
    .MaxStops(MAX_STOPS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .min_value_i       (min_q),
    .clamp_value_i     (clamp_q),
    .categorical_mode_i(cat_q),
    .item_cmd_i        (cmd_i),
    .sample_value_i    (sample_value_i),
    .opacity_i         (opacity_i),
    .stop_position_i   (stop_position_i),
    .stop_red_i        (stop_red_i),
    .stop_green_i      (stop_green_i),
    .stop_blue_i       (stop_blue_i),
    .done_o            (done_o),
    .kind_o            (kind_o),
    .out_red_o         (out_red_o),
    .out_green_o       (out_green_o),
    .out_blue_o        (out_blue_o),
    .out_alpha_o       (out_alpha_o)
  );

endmodule

FILE: hdl/cgm_checker.sv
module cgm_checker
  import cgm_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic       done_o,
  input logic [1:0] kind_o,
  input logic [7:0] out_alpha_o
);

  a_done_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy))
    else $error("result without work");

  a_busy_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted beat not worked on");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results back to back");

  a_add_alpha_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (kind_o == KIND_STORED || kind_o == KIND_DROPPED) |-> out_alpha_o == 8'd0)
    else $error("add result with nonzero alpha");

endmodule

bind color_gradient_map_unit cgm_checker u_cgm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .busy       (busy),
  .done_o     (done_o),
  .kind_o     (kind_o),
  .out_alpha_o(out_alpha_o)
);

FILE: tb/sv/color_gradient_map_unit_tb.sv
module color_gradient_map_unit_tb;
  import cgm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TableDepth = 8;
  localparam int unsigned CycleLimit = 400000;

  // APB byte addresses: register index times four
  localparam logic [3:0] AddrMin   = {REG_MIN, 2'b00};
  localparam logic [3:0] AddrClamp = {REG_CLAMP, 2'b00};
  localparam logic [3:0] AddrCat   = {REG_CAT, 2'b00};

  typedef struct {
    logic [1:0] kind;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } color_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        cmd_i = CMD_ADD;
  logic [31:0] sample_value_i = '0;
  logic [7:0]  opacity_i = '0;
  logic [16:0] stop_position_i = '0;
  logic [7:0]  stop_red_i = '0;
  logic [7:0]  stop_green_i = '0;
  logic [7:0]  stop_blue_i = '0;
  logic        done_o;
  logic [1:0]  kind_o;
  logic [7:0]  out_red_o;
  logic [7:0]  out_green_o;
  logic [7:0]  out_blue_o;
  logic [7:0]  out_alpha_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the block: sorted stop table plus the three registers.
  logic [16:0] shadow_pos [TableDepth];
  logic [23:0] shadow_rgb [TableDepth];
  int unsigned shadow_count = 0;
  longint      cfg_min = 0;
  longint      cfg_clamp = 65536;
  bit          cfg_cat = 1'b0;

  color_beat_t pending_colors[$];
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          no_idle = 1'b0;

  color_gradient_map_unit #(.MAX_STOPS(TableDepth)) DUT (.*);

  always #10 clk_i = ~clk_i;

  // Watchdog: generous bound on the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    mismatch_count++;
    $display("[%0t] mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  // One channel blend, truncated like the divider: (lo*(d-f) + hi*f) / d.
  function automatic logic [7:0] blend_channel(logic [7:0] lo, logic [7:0] hi,
                                               longint f, longint d);
    longint c;
    c = (longint'(lo) * (d - f) + longint'(hi) * f) / d;
    if (c > 255) c = 255;
    return c[7:0];
  endfunction

  // Advances the shadow table and returns the color beat the item must produce.
  function automatic color_beat_t map_predict(logic c, logic [31:0] s, logic [7:0] op,
                                              logic [16:0] pos, logic [23:0] rgb);
    color_beat_t r;
    int unsigned slot;
    longint diff, den, norm, q, m, span, frac;
    logic [16:0] lo_pos;
    logic [23:0] lo_rgb;
    r = '{kind: KIND_COLOR, red: 8'd0, green: 8'd0, blue: 8'd0, alpha: 8'd0};
    if (c == CMD_ADD) begin
      if (shadow_count >= TableDepth) begin
        r.kind = KIND_DROPPED;
        return r;
      end
      slot = 0;
      while (slot < shadow_count && shadow_pos[slot] <= pos) slot++;
      for (int i = shadow_count; i > slot; i--) begin
        shadow_pos[i] = shadow_pos[i-1];
        shadow_rgb[i] = shadow_rgb[i-1];
      end
      shadow_pos[slot] = pos;
      shadow_rgb[slot] = rgb;
      shadow_count++;
      r.kind = KIND_STORED;
      return r;
    end
    diff = longint'(signed'(s)) - cfg_min;
    if (cfg_cat) begin
      r.alpha = 8'hFF;
      if (shadow_count == 0) return r;
      // floor division, then non-negative remainder
      q = (diff >= 0) ? diff / 65536 : -((-diff + 65535) / 65536);
      m = q % longint'(shadow_count);
      if (m < 0) m += shadow_count;
      {r.red, r.green, r.blue} = shadow_rgb[m];
      return r;
    end
    r.alpha = op;
    den = cfg_clamp - cfg_min;
    if (den == 0) norm = 131071;
    else begin
      norm = (diff * 65536) / den;
      if (norm < 0) norm = 0;
      if (norm > 131071) norm = 131071;
    end
    // black stop at 0 stands in below the first stop
    lo_pos = '0;
    lo_rgb = '0;
    for (int i = 0; i < shadow_count; i++) begin
      if (longint'(shadow_pos[i]) > norm) begin
        span = shadow_pos[i] - lo_pos;
        frac = norm - lo_pos;
        r.red   = blend_channel(lo_rgb[23:16], shadow_rgb[i][23:16], frac, span);
        r.green = blend_channel(lo_rgb[15:8], shadow_rgb[i][15:8], frac, span);
        r.blue  = blend_channel(lo_rgb[7:0], shadow_rgb[i][7:0], frac, span);
        return r;
      end
      lo_pos = shadow_pos[i];
      lo_rgb = shadow_rgb[i];
    end
    {r.red, r.green, r.blue} = lo_rgb;
    return r;
  endfunction

  // Result checker: every strobed beat against the oldest expectation.
  always @(posedge clk_i) begin
    color_beat_t want;
    if (rst_ni && done_o) begin
      if (pending_colors.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = pending_colors.pop_front();
        if (kind_o !== want.kind) report_mismatch("kind", kind_o, want.kind);
        if (out_red_o !== want.red) report_mismatch("red", out_red_o, want.red);
        if (out_green_o !== want.green) report_mismatch("green", out_green_o, want.green);
        if (out_blue_o !== want.blue) report_mismatch("blue", out_blue_o, want.blue);
        if (out_alpha_o !== want.alpha) report_mismatch("alpha", out_alpha_o, want.alpha);
      end
    end
  end

  // Mostly short gaps, a few long ones; none while no_idle is set.
  task automatic idle_gap();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_idle || pick < 60) return;
    if (pick < 94) repeat ($urandom_range(1, 3)) @(negedge clk_i);
    else repeat ($urandom_range(10, 40)) @(negedge clk_i);
  endtask

  // Sends one command beat and records what it must return.
  task automatic send_item(logic c, logic [31:0] s, logic [7:0] op,
                           logic [16:0] pos, logic [23:0] rgb);
    idle_gap();
    @(negedge clk_i);
    start <= 1'b1;
    cmd_i <= c;
    sample_value_i <= s;
    opacity_i <= op;
    stop_position_i <= pos;
    {stop_red_i, stop_green_i, stop_blue_i} <= rgb;
    do @(posedge clk_i); while (busy);
    pending_colors = {pending_colors, map_predict(c, s, op, pos, rgb)};
    @(negedge clk_i);
    start <= 1'b0;
  endtask

  task automatic add_stop(logic [16:0] pos, logic [23:0] rgb);
    send_item(CMD_ADD, $urandom, $urandom, pos, rgb);
  endtask

  task automatic look_up(logic [31:0] s, logic [7:0] op);
    send_item(CMD_LOOKUP, s, op, $urandom, $urandom);
  endtask

  // Block drained: every result in and busy low.
  task automatic drain();
    while (pending_colors.size() != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(logic [3:0] addr, logic [31:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (addr)
      AddrMin:   cfg_min = longint'(signed'(data));
      AddrClamp: cfg_clamp = longint'(signed'(data));
      AddrCat:   cfg_cat = data[0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] lo, logic [31:0] hi, bit cat);
    drain();
    apb_write(AddrMin, lo);
    apb_write(AddrClamp, hi);
    apb_write(AddrCat, {31'd0, cat});
  endtask

  // Samples concentrated in and around the mapped range, with some wild ones.
  function automatic logic [31:0] pick_sample();
    longint span, v;
    span = cfg_clamp - cfg_min;
    if ($urandom_range(0, 9) < 3) return $urandom;
    if (cfg_cat) v = cfg_min + longint'($urandom_range(0, 40 * 65536)) - 20 * 65536;
    else v = cfg_min + (span * longint'($urandom_range(0, 1200))) / 1000
             - longint'($urandom_range(0, 255));
    return v[31:0];
  endfunction

  // Empty table in both modes, partial tables, duplicates, edge positions, full table.
  task automatic test_directed();
    set_config(32'd0, 32'd65536, 1'b0);
    look_up(32'd0, 8'hFF);
    drain();
    apb_write(AddrCat, 32'd1);
    look_up(32'hFFFF_0000, 8'h00);
    drain();
    apb_write(AddrCat, 32'd0);
    add_stop(17'd32768, 24'hFF0000);
    look_up(32'd0, 8'h80);
    look_up(32'd16384, 8'h7F);
    look_up(32'd65536, 8'hFF);
    add_stop(17'd0, 24'h00FF00);
    add_stop(17'd32768, 24'h0000FF);
    add_stop(17'd65536, 24'hFFFFFF);
    add_stop(17'h1FFFF, 24'h010203);
    look_up(32'd40000, 8'h55);
    add_stop(17'd65536, 24'hAA55AA);
    add_stop(17'd0, 24'h123456);
    add_stop(17'd100, 24'hFEDCBA);
    add_stop(17'd5, 24'h000000);
    look_up(32'h8000_0000, 8'h01);
    look_up(32'h7FFF_FFFF, 8'hFE);
    look_up(32'd50, 8'h00);
    look_up(32'd32768, 8'hFF);
    look_up(32'd100000, 8'h33);
  endtask

  // One random phase under the current configuration.
  task automatic test_random_phase(int unsigned beats);
    for (int unsigned n = 0; n < beats; n++) begin
      if ($urandom_range(0, 59) == 0) drain();
      if ($urandom_range(0, 7) == 0) add_stop($urandom_range(0, 17'h1FFFF), $urandom);
      else look_up(pick_sample(), $urandom);
    end
  endtask

  task automatic test_gradient_settings();
    set_config(32'd0, 32'd65536, 1'b0);
    test_random_phase(80);
    set_config(32'hFFFC_0000, 32'h0004_0000, 1'b0);
    test_random_phase(80);
    // inverted range: negative divisor
    set_config(32'h0001_0000, 32'hFFFF_0000, 1'b0);
    test_random_phase(60);
    // extremes of both registers
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
    test_random_phase(60);
    set_config(32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
    test_random_phase(40);
    // zero divisor
    set_config(32'h0000_1234, 32'h0000_1234, 1'b0);
    test_random_phase(40);
  endtask

  task automatic test_categorical_settings();
    set_config(32'd0, 32'd65536, 1'b1);
    test_random_phase(80);
    set_config(32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    test_random_phase(40);
    set_config(32'h7FFF_FFFF, 32'd0, 1'b1);
    no_idle = 1'b1;
    test_random_phase(40);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_gradient_settings();
    test_categorical_settings();
    drain();
    repeat (60) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: color_gradient_map_unit.f
hdl/cgm_pkg.sv
hdl/cgm_ctrl.sv
hdl/cgm_dp.sv
hdl/color_gradient_map_unit.sv
hdl/cgm_checker.sv
tb/sv/color_gradient_map_unit_tb.sv
